FILE: rtl/h2rgb_pkg.sv
`timescale 1ns / 1ps

package h2rgb_pkg;

  // field widths
  localparam int HUE_W = 9;
  localparam int SAT_W = 9;
  localparam int INT_W = 8;
  localparam int CH_W  = 8;

  // fixed-point formats
  localparam int RATIO_FRAC_BITS = 14;
  localparam int SAT_FRAC_BITS   = 8;
  localparam int SHIFT           = SAT_FRAC_BITS + RATIO_FRAC_BITS;
  localparam int RATIO_W         = RATIO_FRAC_BITS + 3;
  localparam int SATX_W          = SAT_W + 1;
  localparam int LOWP_W          = INT_W + SATX_W + 1;
  localparam int SR_W            = RATIO_W + SATX_W;
  localparam int FACT_W          = SR_W + 1;
  localparam int NUM_W           = SR_W + INT_W + 3;
  localparam int VAL_W           = NUM_W - SHIFT + 1;

  // hue geometry
  localparam int HUE_FULL   = 360;
  localparam int SECTOR_DEG = 120;
  localparam int H_W        = $clog2(SECTOR_DEG);

  // cosine series constants
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam int TAYLOR_TERMS     = 12;

  typedef enum logic [1:0] {
    SECTOR_RG = 2'd0,
    SECTOR_GB = 2'd1,
    SECTOR_BR = 2'd2
  } sector_e;

  typedef logic signed [RATIO_W-1:0] ratio_t;
  typedef ratio_t ratio_rom_t [SECTOR_DEG];

  // channel numerators handed to the output stage
  typedef struct packed {
    sector_e                   sector;
    logic [INT_W-1:0]          intensity;
    logic signed [NUM_W-1:0]   low;
    logic signed [NUM_W-1:0]   mid;
  } num_t;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int n = 63; n >= 0; n--) begin
      rem = {rem[63:0], a[n]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[n] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cosine of 0..90 degrees in q30
  function automatic logic signed [63:0] cos_q1(input int unsigned d);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    x    = (64'(d) * PI_Q30 + 64'd90) / 180;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = ONE_Q30;
    pos  = ONE_Q30;
    neg  = '0;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = udiv((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
      if (k % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return $signed(pos) - $signed(neg);
  endfunction

  // cosine of 0..180 degrees in q30
  function automatic logic signed [63:0] cos_deg(input int unsigned d);
    if (d > 90) begin
      return -cos_q1(180 - d);
    end
    return cos_q1(d);
  endfunction

  // cos(h) / cos(60 - h), rounded half away from zero
  function automatic ratio_t ratio_entry(input int unsigned h);
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic [63:0]        mag;
    logic [63:0]        q;
    num = cos_deg(h);
    den = cos_deg((h <= 60) ? (60 - h) : (h - 60));
    mag = (num < 0) ? 64'(-num) : 64'(num);
    if (den <= 0) begin
      return '0;
    end
    q = udiv((mag << RATIO_FRAC_BITS) + (64'(den) >> 1), 64'(den));
    if (num < 0) begin
      return RATIO_W'(-$signed(q));
    end
    return RATIO_W'(q);
  endfunction

  function automatic ratio_rom_t build_ratio_rom();
    ratio_rom_t rom;
    for (int h = 0; h < SECTOR_DEG; h++) begin
      rom[h] = ratio_entry(h);
    end
    return rom;
  endfunction

  localparam ratio_rom_t RATIO_ROM = build_ratio_rom();

  // round half up, clamp to 0..255
  function automatic logic [CH_W-1:0] finish_channel(input logic signed [NUM_W-1:0] n);
    logic [VAL_W-1:0] v;
    if (n < 0) begin
      return '0;
    end
    v = VAL_W'(n[NUM_W-1:SHIFT]) + VAL_W'(n[SHIFT-1]);
    if (v > VAL_W'((1 << CH_W) - 1)) begin
      return '1;
    end
    return v[CH_W-1:0];
  endfunction

endpackage

FILE: rtl/h2rgb_if.sv
`timescale 1ns / 1ps

// hsi pixel channel
interface h2rgb_hsi_if import h2rgb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [INT_W-1:0] intensity;

  modport source (output valid, hue, saturation, intensity, input ready);
  modport sink   (input valid, hue, saturation, intensity, output ready);
endinterface

// rgb pixel channel
interface h2rgb_rgb_if import h2rgb_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: rtl/h2rgb_finish.sv
`timescale 1ns / 1ps

module h2rgb_finish import h2rgb_pkg::*; (
  input  num_t            num_i,
  output logic [CH_W-1:0] red_o,
  output logic [CH_W-1:0] green_o,
  output logic [CH_W-1:0] blue_o
);

  logic signed [NUM_W-1:0] i_d;
  logic signed [NUM_W-1:0] rest;
  logic [CH_W-1:0]         low_c;
  logic [CH_W-1:0]         mid_c;
  logic [CH_W-1:0]         rest_c;

  // rest = 3*I*D - low - mid
  always_comb begin
    i_d  = NUM_W'($signed({1'b0, num_i.intensity})) <<< SHIFT;
    rest = i_d + (i_d <<< 1) - num_i.low - num_i.mid;
  end

  assign low_c  = finish_channel(num_i.low);
  assign mid_c  = finish_channel(num_i.mid);
  assign rest_c = finish_channel(rest);

  // route channels by sector
  always_comb begin
    case (num_i.sector)
      SECTOR_RG: begin
        red_o   = mid_c;
        green_o = rest_c;
        blue_o  = low_c;
      end
      SECTOR_GB: begin
        red_o   = low_c;
        green_o = mid_c;
        blue_o  = rest_c;
      end
      default: begin
        red_o   = rest_c;
        green_o = low_c;
        blue_o  = mid_c;
      end
    endcase
  end

endmodule

FILE: rtl/hsi_to_rgb_pixel.sv
`timescale 1ns / 1ps

// hsi to rgb pixel converter
// input channel hsi_i carries hue (degrees, 360..511 wrap), saturation
// (256 = 1.0) and intensity; output channel rgb_o carries red, green, blue.
// both channels use valid/ready; a word moves when both are high.
// five register stages: hue split, ratio table and low product,
// saturation times ratio, intensity times mid factor, rounding and routing.
// throughput is one word per cycle while rgb_o is ready; each stage holds one word and is
// refilled as soon as the next stage takes its word, so bubbles close up.
// when rgb_o stalls, the pipe keeps filling until all stages hold a word,
// then hsi_i.ready drops; no word is lost or repeated.
// reset clears all stage valid bits; the pipe is empty and ready at once.
// there is no configuration and no state kept between pixels.
module hsi_to_rgb_pixel import h2rgb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  h2rgb_hsi_if.sink   hsi_i,
  h2rgb_rgb_if.source rgb_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  // stage enables, each stage loads when empty or when drained downstream
  assign en5 = !v5_q || rgb_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign hsi_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= hsi_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: wrap hue, pick sector and angle within it
  logic [HUE_W-1:0] hue_w;
  sector_e          sector1_d, sector1_q;
  logic [H_W-1:0]   h1_d, h1_q;
  logic [SAT_W-1:0] sat1_q;
  logic [INT_W-1:0] int1_q;

  always_comb begin
    hue_w = (hsi_i.hue >= HUE_W'(HUE_FULL)) ? hsi_i.hue - HUE_W'(HUE_FULL) : hsi_i.hue;
    if (hue_w < HUE_W'(SECTOR_DEG)) begin
      sector1_d = SECTOR_RG;
      h1_d      = H_W'(hue_w);
    end else if (hue_w < HUE_W'(2 * SECTOR_DEG)) begin
      sector1_d = SECTOR_GB;
      h1_d      = H_W'(hue_w - HUE_W'(SECTOR_DEG));
    end else begin
      sector1_d = SECTOR_BR;
      h1_d      = H_W'(hue_w - HUE_W'(2 * SECTOR_DEG));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sector1_q <= sector1_d;
      h1_q      <= h1_d;
      sat1_q    <= hsi_i.saturation;
      int1_q    <= hsi_i.intensity;
    end
  end

  // stage 2: ratio lookup, low product I*(1-S)
  logic signed [SATX_W-1:0] one_minus_s;
  logic signed [LOWP_W-1:0] lowp2_d, lowp2_q;
  ratio_t                   ratio2_q;
  sector_e                  sector2_q;
  logic [SAT_W-1:0]         sat2_q;
  logic [INT_W-1:0]         int2_q;

  always_comb begin
    one_minus_s = SATX_W'(1 << SAT_FRAC_BITS) - $signed({1'b0, sat1_q});
    lowp2_d     = LOWP_W'($signed({1'b0, int1_q})) * LOWP_W'(one_minus_s);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ratio2_q  <= RATIO_ROM[h1_q];
      lowp2_q   <= lowp2_d;
      sector2_q <= sector1_q;
      sat2_q    <= sat1_q;
      int2_q    <= int1_q;
    end
  end

  // stage 3: S*ratio
  logic signed [SR_W-1:0]   sr3_d, sr3_q;
  logic signed [LOWP_W-1:0] lowp3_q;
  sector_e                  sector3_q;
  logic [INT_W-1:0]         int3_q;

  assign sr3_d = SR_W'($signed({1'b0, sat2_q})) * SR_W'(ratio2_q);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sr3_q     <= sr3_d;
      lowp3_q   <= lowp2_q;
      sector3_q <= sector2_q;
      int3_q    <= int2_q;
    end
  end

  // stage 4: mid = I*(D + S*ratio), low scaled to D
  logic signed [FACT_W-1:0] factor;
  num_t                     num4_d, num4_q;

  always_comb begin
    factor           = FACT_W'(1 << SHIFT) + FACT_W'(sr3_q);
    num4_d.sector    = sector3_q;
    num4_d.intensity = int3_q;
    num4_d.mid       = NUM_W'($signed({1'b0, int3_q})) * NUM_W'(factor);
    num4_d.low       = NUM_W'(lowp3_q) <<< RATIO_FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      num4_q <= num4_d;
    end
  end

  // stage 5: rest channel, rounding, clamping, routing
  logic [CH_W-1:0] red5_d, green5_d, blue5_d;
  logic [CH_W-1:0] red5_q, green5_q, blue5_q;

  h2rgb_finish u_finish (
    .num_i   (num4_q),
    .red_o   (red5_d),
    .green_o (green5_d),
    .blue_o  (blue5_d)
  );

  always_ff @(posedge clk_i) begin
    if (en5) begin
      red5_q   <= red5_d;
      green5_q <= green5_d;
      blue5_q  <= blue5_d;
    end
  end

  assign rgb_o.valid = v5_q;
  assign rgb_o.red   = red5_q;
  assign rgb_o.green = green5_q;
  assign rgb_o.blue  = blue5_q;

endmodule

FILE: verif/hsi_to_rgb_pixel_test.sv
`timescale 1ns / 1ps

module hsi_to_rgb_pixel_test import h2rgb_pkg::*;;

  // own copy of the fixed-point formats and the cosine series
  localparam int RATIO_Q = 14;
  localparam int SAT_Q   = 8;
  localparam int TOTAL_Q = RATIO_Q + SAT_Q;
  localparam longint ONE_D = 64'sd1 <<< TOTAL_Q;
  localparam longint unsigned PI_Q30_TB = 64'd3373259426;
  localparam int SERIES_TERMS = 12;

  localparam int N_DIRECTED   = 23;
  localparam int N_RANDOM     = 1727;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AFTER   = 400;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_px_t;

  // directed row: typed = 1 means the expected word is given in the row
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [INT_W-1:0] inten;
    logic             typed;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n;

  h2rgb_hsi_if hsi ();
  h2rgb_rgb_if rgb ();

  hsi_to_rgb_pixel DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .hsi_i  (hsi),
    .rgb_o  (rgb)
  );

  longint  ratio_q14 [SECTOR_DEG];
  rgb_px_t rgb_due [$];
  int      accepted_px = 0;
  int      checked_px  = 0;
  int      fail_count  = 0;
  int      burst_left  = 0;

  pixel_row_t directed_rows [N_DIRECTED] = '{
    // black, gray and fully saturated primaries
    '{9'd0,   9'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{9'd0,   9'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{9'd200, 9'd0,   8'd128, 1'b1, 8'd128, 8'd128, 8'd128},
    '{9'd255, 9'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{9'd0,   9'd256, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    '{9'd120, 9'd256, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
    '{9'd240, 9'd256, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
    '{9'd0,   9'd256, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    // hue past 359 wraps around
    '{9'd360, 9'd256, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
    '{9'd480, 9'd256, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
    '{9'd511, 9'd511, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    // sector ends, negative ratio, saturation above one
    '{9'd359, 9'd256, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd119, 9'd256, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd60,  9'd256, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd90,  9'd128, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd100, 9'd200, 8'd77,  1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd150, 9'd256, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd300, 9'd64,  8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd45,  9'd511, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd200, 9'd257, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd400, 9'd300, 8'd90,  1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd511, 9'd511, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{9'd30,  9'd85,  8'd170, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cosine of 0..90 degrees in q30 by taylor series
  function automatic longint cos_quadrant_q30(input int unsigned deg);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned plus;
    longint unsigned minus;
    int              k;
    ang    = (64'(deg) * PI_Q30_TB + 64'd90) / 64'd180;
    ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
    term   = 64'd1 << 30;
    plus   = term;
    minus  = 64'd0;
    for (k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        minus = minus + term;
      end else begin
        plus = plus + term;
      end
    end
    return $signed(plus) - $signed(minus);
  endfunction

  // cosine of 0..180 degrees in q30, signed
  function automatic longint cos_half_q30(input int unsigned deg);
    if (deg > 90) begin
      return -cos_quadrant_q30(180 - deg);
    end
    return cos_quadrant_q30(deg);
  endfunction

  // cos(h) / cos(60 - h) in q14, rounded half away from zero
  function automatic longint cos_ratio_q14(input int unsigned h);
    longint          num;
    longint          den;
    longint unsigned mag;
    longint unsigned q;
    num = cos_half_q30(h);
    den = cos_half_q30((h <= 60) ? 60 - h : h - 60);
    if (den <= 0) begin
      return 0;
    end
    mag = (num < 0) ? $unsigned(-num) : $unsigned(num);
    q   = ((mag << RATIO_Q) + ($unsigned(den) >> 1)) / $unsigned(den);
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  // numerator over ONE_D, rounded half up and clamped to a channel
  function automatic logic [CH_W-1:0] channel_level(input longint n);
    longint v;
    if (n < 0) begin
      return '0;
    end
    v = (n + (64'sd1 <<< (TOTAL_Q - 1))) >>> TOTAL_Q;
    return (v > 255) ? 8'd255 : v[CH_W-1:0];
  endfunction

  // expected rgb word for one hsi word
  function automatic rgb_px_t predict_rgb(input logic [HUE_W-1:0] hue,
                                          input logic [SAT_W-1:0] sat,
                                          input logic [INT_W-1:0] inten);
    int unsigned     deg;
    int unsigned     h;
    sector_e         sec;
    longint          s;
    longint          i;
    longint          lo_n;
    longint          mid_n;
    longint          rest_n;
    logic [CH_W-1:0] lo_c;
    logic [CH_W-1:0] mid_c;
    logic [CH_W-1:0] rest_c;
    rgb_px_t         px;
    deg = hue;
    if (deg >= 360) begin
      deg = deg - 360;
    end
    sec    = sector_e'(deg / SECTOR_DEG);
    h      = deg - SECTOR_DEG * (deg / SECTOR_DEG);
    s      = longint'(sat);
    i      = longint'(inten);
    lo_n   = i * ((64'sd1 <<< SAT_Q) - s) * (64'sd1 <<< RATIO_Q);
    mid_n  = i * (ONE_D + s * ratio_q14[h]);
    rest_n = 3 * i * ONE_D - lo_n - mid_n;
    lo_c   = channel_level(lo_n);
    mid_c  = channel_level(mid_n);
    rest_c = channel_level(rest_n);
    case (sec)
      SECTOR_RG: px = '{red: mid_c, green: rest_c, blue: lo_c};
      SECTOR_GB: px = '{red: lo_c, green: mid_c, blue: rest_c};
      default:   px = '{red: rest_c, green: lo_c, blue: mid_c};
    endcase
    return px;
  endfunction

  // offer one hsi word in bursts with random gaps, hold it until taken
  task automatic offer_pixel(input logic [HUE_W-1:0] hue, input logic [SAT_W-1:0] sat,
                             input logic [INT_W-1:0] inten, input rgb_px_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        hsi.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    hsi.valid      <= 1'b1;
    hsi.hue        <= hue;
    hsi.saturation <= sat;
    hsi.intensity  <= inten;
    do begin
      @(posedge clk);
    end while (!hsi.ready);
    rgb_due.push_back(want);
    accepted_px++;
  endtask

  // stimulus and end of run
  initial begin : stimulus
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [INT_W-1:0] inten;
    pixel_row_t       row;
    rgb_px_t          want;
    int               n;
    for (n = 0; n < SECTOR_DEG; n++) begin
      ratio_q14[n] = cos_ratio_q14(n);
    end
    rst_n          <= 1'b0;
    hsi.valid      <= 1'b0;
    hsi.hue        <= '0;
    hsi.saturation <= '0;
    hsi.intensity  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    for (n = 0; n < N_DIRECTED; n++) begin
      row  = directed_rows[n];
      want = row.typed ? rgb_px_t'{red: row.red, green: row.green, blue: row.blue}
                       : predict_rgb(row.hue, row.sat, row.inten);
      offer_pixel(row.hue, row.sat, row.inten, want);
    end

    // random words, weighted toward sector edges and extreme levels
    for (n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0:       hue = HUE_W'($urandom_range(360, 511));
        1:       hue = HUE_W'($urandom_range(0, 2) * SECTOR_DEG +
                              ($urandom_range(0, 1) ? 0 : 119));
        default: hue = HUE_W'($urandom_range(0, 359));
      endcase
      case ($urandom_range(0, 7))
        0:       sat = '0;
        1:       sat = 9'd256;
        2:       sat = SAT_W'($urandom_range(257, 511));
        default: sat = SAT_W'($urandom_range(0, 256));
      endcase
      case ($urandom_range(0, 9))
        0:       inten = '0;
        1:       inten = 8'd255;
        default: inten = INT_W'($urandom_range(0, 255));
      endcase
      offer_pixel(hue, sat, inten, predict_rgb(hue, sat, inten));
    end
    hsi.valid <= 1'b0;

    // let the pipe drain, then watch for stray words
    while (rgb_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && rgb_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver: changing stall patterns plus one long hold-off
  initial begin : drain
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    bit          held;
    held  = 1'b0;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      repeat (span) begin
        if (!held && accepted_px >= HOLD_AFTER) begin
          held = 1'b1;
          rgb.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        phase++;
        case (mode)
          0:       rgb.ready <= 1'b1;
          1:       rgb.ready <= 1'($urandom_range(0, 1));
          2:       rgb.ready <= (phase % 3 != 0);
          default: rgb.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // compare each taken rgb word with the oldest expected one
  always @(posedge clk) begin
    rgb_px_t want;
    if (rst_n && rgb.valid && rgb.ready) begin
      checked_px++;
      if (rgb_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected rgb word %0d: r=%0d g=%0d b=%0d",
                   checked_px, rgb.red, rgb.green, rgb.blue);
        end
      end else begin
        want = rgb_due.pop_front();
        if (rgb.red !== want.red || rgb.green !== want.green || rgb.blue !== want.blue) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("rgb word %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     checked_px, want.red, want.green, want.blue,
                     rgb.red, rgb.green, rgb.blue);
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((hsi.valid && hsi.ready) || (rgb.valid && rgb.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
